// ===== hdl/drs_pkg.sv =====
`default_nettype none

package drs_pkg;

  localparam int unsigned VAL_W      = 20;
  localparam int unsigned MOVE_W     = 10;
  localparam int unsigned RADIX      = 10;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } entry_t;

endpackage

`default_nettype wire

// ===== hdl/drs_front.sv =====
`default_nettype none

module drs_front #(
  parameter int unsigned MAX_ITEMS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            stall_o,
  input  wire logic [drs_pkg::VAL_W-1:0]  value_i,
  input  wire logic                       last_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output drs_pkg::entry_t                 entry_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             set_end;

  // set ends on last flag or when the store fills
  assign set_end = last_i || (cnt_q == CNT_W'(MAX_ITEMS - 1));
  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

  assign entry_o.value = value_i;
  assign entry_o.last  = set_end;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = set_end ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/drs_fifo.sv =====
`default_nettype none

module drs_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire drs_pkg::entry_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output drs_pkg::entry_t       entry_o,
  output logic                  empty_o
);

  drs_pkg::entry_t                     mem_q [drs_pkg::FIFO_DEPTH];
  logic [drs_pkg::FIFO_PTR_W-1:0]      wptr_q, rptr_q;
  logic [drs_pkg::FIFO_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                do_push, do_pop;

  assign full_o  = (cnt_q == drs_pkg::FIFO_CNT_W'(drs_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/drs_back.sv =====
`default_nettype none

module drs_back #(
  parameter int unsigned MAX_ITEMS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  wire drs_pkg::entry_t             entry_i,
  output logic                             pop_o,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic [drs_pkg::VAL_W-1:0]        sorted_value_o,
  output logic                             last_res_o,
  output logic [drs_pkg::MOVE_W-1:0]       move_count_o
);

  localparam int unsigned VAL_W   = drs_pkg::VAL_W;
  localparam int unsigned DIG_W   = drs_pkg::DIG_W;
  localparam int unsigned MOVE_W  = drs_pkg::MOVE_W;
  localparam int unsigned RADIX   = drs_pkg::RADIX;
  localparam int unsigned IDX_W   = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EL_W    = 2 * VAL_W;
  localparam int unsigned PROD_W  = 2 * VAL_W;
  localparam int unsigned DIV10_SHIFT = 23;
  localparam logic [VAL_W-1:0] DIV10_MUL = VAL_W'(838861);

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_COUNT   = 3'd2;
  localparam logic [2:0] S_PREFIX  = 3'd3;
  localparam logic [2:0] S_SCAT    = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_WR = 3'd6;

  // element word: {quotient value / 10^pass, value}
  logic [EL_W-1:0]   mem_a [MAX_ITEMS];
  logic [EL_W-1:0]   mem_b [MAX_ITEMS];
  logic [EL_W-1:0]   rd_a_q, rd_b_q, rd_el;

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d, n_q, n_d, acc_q, acc_d, idx_m1;
  logic [VAL_W-1:0]  max_q, max_d, new_max;
  logic [PROD_W-1:0] maxp_q, maxp_d;
  logic [MOVE_W-1:0] moves_q, moves_d;
  logic              src_q, src_d;
  logic [CNT_W-1:0]  cnt_q [RADIX];
  logic [CNT_W-1:0]  cnt_d [RADIX];
  logic [DIG_W-1:0]  pidx_q, pidx_d;

  logic              p1_q, p1_d, p2_q;
  logic [PROD_W-1:0] prod_q;
  logic [VAL_W-1:0]  q2_q, v2_q;

  logic [VAL_W-1:0]  quot, quot10, rem;
  logic [DIG_W-1:0]  digit, rsel;
  logic [CNT_W-1:0]  cnt_rd, pos;
  logic [IDX_W-1:0]  raddr, wa_addr, wb_addr;
  logic [EL_W-1:0]   w_data;
  logic              wa_en, wb_en, out_free;

  logic              ovld_q, ovld_d, olast_q, olast_d;
  logic [VAL_W-1:0]  oval_q, oval_d;
  logic [MOVE_W-1:0] omoves_q, omoves_d;

  assign idx_m1   = idx_q - 1'b1;
  assign rd_el    = src_q ? rd_b_q : rd_a_q;
  assign quot     = VAL_W'(prod_q >> DIV10_SHIFT);
  assign quot10   = (quot << 3) + (quot << 1);
  assign rem      = q2_q - quot10;
  assign digit    = rem[DIG_W-1:0];
  assign rsel     = (state_q == S_PREFIX) ? pidx_q : digit;
  assign cnt_rd   = cnt_q[rsel];
  assign pos      = cnt_rd - 1'b1;
  assign out_free = !ovld_q || !stall_i;
  assign new_max  = (entry_i.value > max_q) ? entry_i.value : max_q;
  assign raddr    = (state_q == S_SCAT) ? idx_m1[IDX_W-1:0] : idx_q[IDX_W-1:0];

  assign valid_o        = ovld_q;
  assign sorted_value_o = oval_q;
  assign last_res_o     = olast_q;
  assign move_count_o   = omoves_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    n_d      = n_q;
    acc_d    = acc_q;
    max_d    = max_q;
    maxp_d   = maxp_q;
    moves_d  = moves_q;
    src_d    = src_q;
    pidx_d   = pidx_q;
    cnt_d    = cnt_q;
    p1_d     = 1'b0;
    pop_o    = 1'b0;
    wa_en    = 1'b0;
    wb_en    = 1'b0;
    wa_addr  = pos[IDX_W-1:0];
    wb_addr  = pos[IDX_W-1:0];
    w_data   = {quot, v2_q};
    ovld_d   = ovld_q && stall_i;
    oval_d   = oval_q;
    olast_d  = olast_q;
    omoves_d = omoves_q;

    case (state_q)
      S_LOAD: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          wa_en   = 1'b1;
          wa_addr = idx_q[IDX_W-1:0];
          w_data  = {entry_i.value, entry_i.value};
          max_d   = new_max;
          if (entry_i.last) begin
            n_d     = idx_q + 1'b1;
            idx_d   = '0;
            moves_d = '0;
            src_d   = 1'b0;
            state_d = S_CHECK;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_CHECK: begin
        idx_d = '0;
        if (max_q == '0) begin
          state_d = S_EMIT_RD;
        end else begin
          for (int k = 0; k < RADIX; k++) begin
            cnt_d[k] = '0;
          end
          maxp_d  = PROD_W'(max_q) * PROD_W'(DIV10_MUL);
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (idx_q != n_q) begin
          p1_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end
        if (p2_q) begin
          cnt_d[digit] = cnt_rd + 1'b1;
        end
        if (idx_q == n_q && !p1_q && !p2_q) begin
          acc_d   = '0;
          pidx_d  = '0;
          state_d = S_PREFIX;
        end
      end
      S_PREFIX: begin
        cnt_d[pidx_q] = acc_q + cnt_rd;
        acc_d         = acc_q + cnt_rd;
        if (pidx_q == DIG_W'(RADIX - 1)) begin
          idx_d   = n_q;
          state_d = S_SCAT;
        end else begin
          pidx_d = pidx_q + 1'b1;
        end
      end
      S_SCAT: begin
        if (idx_q != '0) begin
          p1_d  = 1'b1;
          idx_d = idx_m1;
        end
        if (p2_q) begin
          cnt_d[digit] = pos;
          if (src_q) begin
            wa_en = 1'b1;
          end else begin
            wb_en = 1'b1;
          end
        end
        if (idx_q == '0 && !p1_q && !p2_q) begin
          moves_d = moves_q + MOVE_W'({n_q, 1'b0});
          max_d   = VAL_W'(maxp_q >> DIV10_SHIFT);
          src_d   = !src_q;
          state_d = S_CHECK;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          ovld_d   = 1'b1;
          oval_d   = rd_el[VAL_W-1:0];
          olast_d  = (idx_q == n_q - 1'b1);
          omoves_d = moves_q;
          if (idx_q == n_q - 1'b1) begin
            idx_d   = '0;
            max_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      idx_q   <= '0;
      n_q     <= '0;
      acc_q   <= '0;
      max_q   <= '0;
      moves_q <= '0;
      src_q   <= 1'b0;
      pidx_q  <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      ovld_q  <= 1'b0;
      for (int k = 0; k < RADIX; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      acc_q   <= acc_d;
      max_q   <= max_d;
      moves_q <= moves_d;
      src_q   <= src_d;
      pidx_q  <= pidx_d;
      p1_q    <= p1_d;
      p2_q    <= p1_q;
      ovld_q  <= ovld_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    maxp_q   <= maxp_d;
    prod_q   <= PROD_W'(rd_el[EL_W-1:VAL_W]) * PROD_W'(DIV10_MUL);
    q2_q     <= rd_el[EL_W-1:VAL_W];
    v2_q     <= rd_el[VAL_W-1:0];
    oval_q   <= oval_d;
    olast_q  <= olast_d;
    omoves_q <= omoves_d;
  end

  always_ff @(posedge clk_i) begin
    if (wa_en) begin
      mem_a[wa_addr] <= w_data;
    end
    rd_a_q <= mem_a[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      mem_b[wb_addr] <= w_data;
    end
    rd_b_q <= mem_b[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/decimal_lsd_radix_sort_top.sv =====
// Load: one item per cycle through a 4-entry queue while the sorter is loading.
// Sort: per decimal pass a count sweep, a 10-step prefix and a scatter sweep over
// one-read/one-write element memories; passes = digits of the maximum.
// Output: each sorted item takes a read state, then a write state held while stalled.
// Reset: asynchronous, active low; clears control, counts and queue; memories are
// not cleared.
`default_nettype none

module decimal_lsd_radix_sort_top #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             stall_o,
  input  wire logic [drs_pkg::VAL_W-1:0]   value_i,
  input  wire logic                        last_i,
  output logic                             valid_o,
  input  wire logic                        stall_i,
  output logic [drs_pkg::VAL_W-1:0]        sorted_value_o,
  output logic                             last_res_o,
  output logic [drs_pkg::MOVE_W-1:0]       move_count_o
);

  drs_pkg::entry_t push_entry, pop_entry;
  logic            push, pop, full, empty;

  drs_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .value_i (value_i),
    .last_i  (last_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  drs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  drs_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .sorted_value_o (sorted_value_o),
    .last_res_o     (last_res_o),
    .move_count_o   (move_count_o)
  );

endmodule

`default_nettype wire
